// ===== rtl/hkt_pkg.sv =====
// ----------------------------------------------------------------------------
// Hash key table package
// Shared widths, status codes and the memory request type.
// ----------------------------------------------------------------------------
package hkt_pkg;

  localparam int SLOTS      = 256;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int SIZE_W     = SLOT_W + 1;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int PROD_W     = 64;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  localparam logic [0:0] OP_PUT = 1'b0;
  localparam logic [0:0] OP_GET = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_ZERO_KEY  = 3'd5
  } status_t;

  typedef struct packed {
    logic                  rd_en;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  key_wr;
    logic                  val_wr;
    logic [SLOT_W-1:0]     wr_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_val;
  } mem_req_t;

endpackage

// ===== rtl/hkt_hash.sv =====
// ----------------------------------------------------------------------------
// Hash key table home slot unit
// Multiplies the key, shifts by the leading-zero count of the size and
// reduces modulo the size one bit per cycle.
// ----------------------------------------------------------------------------
module hkt_hash import hkt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [KEY_BITS-1:0] key,
  input  logic [SIZE_W-1:0]   size,
  output logic                done,
  output logic [SLOT_W-1:0]   home
);

  typedef enum logic [1:0] {H_IDLE, H_MUL, H_SHIFT, H_DIV} hstate_t;

  hstate_t                 state_r;
  logic [PROD_W-1:0]       prod_r;
  logic [PROD_W-1:0]       sh_r;
  logic [SIZE_W-1:0]       rem_r;
  logic [5:0]              cnt_r;
  logic                    done_r;
  logic [4:0]              lz;
  logic [SIZE_W:0]         trial;
  logic [SIZE_W:0]         rem_nxt;

  always_comb begin
    lz = 5'd31;
    for (int i = 0; i < SIZE_W; i++) begin
      if (size[i]) begin
        lz = 5'(31 - i);
      end
    end
  end

  assign trial   = {rem_r, sh_r[PROD_W-1]};
  assign rem_nxt = (trial >= {1'b0, size}) ? trial - {1'b0, size} : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == H_DIV) && (cnt_r == 6'(PROD_W - 1));
      unique case (state_r)
        H_IDLE: begin
          if (start) begin
            prod_r  <= PROD_W'(key) * PROD_W'(HASH_MULT);
            state_r <= H_MUL;
          end
        end
        H_MUL: begin
          sh_r    <= prod_r >> lz;
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= H_SHIFT;
        end
        H_SHIFT: begin
          state_r <= H_DIV;
        end
        H_DIV: begin
          rem_r <= rem_nxt[SIZE_W-1:0];
          sh_r  <= sh_r << 1;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(PROD_W - 1)) begin
            state_r <= H_IDLE;
          end
        end
        default: state_r <= H_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign home = rem_r[SLOT_W-1:0];

endmodule

// ===== rtl/hkt_store.sv =====
// ----------------------------------------------------------------------------
// Hash key table store
// Key and value memories with registered reads; per-slot valid bits make an
// unwritten key read as empty.
// ----------------------------------------------------------------------------
module hkt_store import hkt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mem_req_t              req,
  output logic [KEY_BITS-1:0]   key_rd,
  output logic [VALUE_BITS-1:0] val_rd
);

  logic [KEY_BITS-1:0]   key_mem [SLOTS];
  logic [VALUE_BITS-1:0] val_mem [SLOTS];
  logic [SLOTS-1:0]      vld_r;
  logic [KEY_BITS-1:0]   key_q_r;
  logic                  vld_q_r;

  always_ff @(posedge clk) begin
    if (req.key_wr) begin
      key_mem[req.wr_addr] <= req.wr_key;
    end
    if (req.val_wr) begin
      val_mem[req.wr_addr] <= req.wr_val;
    end
    if (req.rd_en) begin
      key_q_r <= key_mem[req.rd_addr];
      val_rd  <= val_mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (req.key_wr) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        vld_q_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign key_rd = vld_q_r ? key_q_r : '0;

endmodule

// ===== rtl/multiplicative_hash_key_table_core.sv =====
// ----------------------------------------------------------------------------
// Multiplicative hash key table core
// Key/value table with put and get requests, one request at a time.
// ----------------------------------------------------------------------------
// A request first finds its home slot (one multiply, a shift and a
// 64-step bit-serial modulo), then reads the home slot, and then scans
// one slot per cycle through the single read port of the key memory:
// up to the table size for a put of a new key, up to the overflow mark
// for a missed get. A zero key is answered without hashing. The table
// size may be written only while no key has been stored.
module multiplicative_hash_key_table_core import hkt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_status,
  output logic [31:0]           out_read_value,
  output logic [SLOT_W-1:0]     out_slot,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SIZE_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_HASH, S_HOME_RD, S_HOME_CHK, S_SCAN, S_DONE} state_t;

  state_t                state_r, state_nxt;
  logic                  op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [SIZE_W-1:0]     size_r;
  logic [SLOT_W-1:0]     hos_r, hos_nxt;
  logic                  occ_r, occ_nxt;
  logic [SLOT_W-1:0]     home_r, home_nxt;
  logic                  home_empty_r, home_empty_nxt;
  logic [SIZE_W-1:0]     ra_r, ra_nxt;
  logic                  chk_r, chk_nxt;
  logic [SLOT_W-1:0]     chk_slot_r, chk_slot_nxt;
  logic                  free_r, free_nxt;
  logic [SLOT_W-1:0]     free_slot_r, free_slot_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [31:0]           res_value_r, res_value_nxt;
  logic [SLOT_W-1:0]     res_slot_r, res_slot_nxt;
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [31:0]           out_value_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [SIZE_W-1:0]     size_wr;
  logic [SIZE_W-1:0]     lim;
  logic [SIZE_W-1:0]     hos_lim;
  logic                  hash_start, hash_done;
  logic [SLOT_W-1:0]     hash_home;
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  mem_req_t              req;

  hkt_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (key_r),
    .size  (size_r),
    .done  (hash_done),
    .home  (hash_home)
  );

  hkt_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .key_rd (key_rd),
    .val_rd (val_rd)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  always_comb begin
    if (cfg_data == '0) begin
      size_wr = SIZE_W'(1);
    end else if (cfg_data > SIZE_W'(SLOTS)) begin
      size_wr = SIZE_W'(SLOTS);
    end else begin
      size_wr = cfg_data;
    end
  end

  assign hos_lim = {1'b0, hos_r} + SIZE_W'(1);
  assign lim = (op_r == OP_PUT || hos_lim > size_r) ? size_r : hos_lim;

  always_comb begin
    state_nxt      = state_r;
    hos_nxt        = hos_r;
    occ_nxt        = occ_r;
    home_nxt       = home_r;
    home_empty_nxt = home_empty_r;
    ra_nxt         = ra_r;
    chk_nxt        = 1'b0;
    chk_slot_nxt   = chk_slot_r;
    free_nxt       = free_r;
    free_slot_nxt  = free_slot_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_slot_nxt   = res_slot_r;
    hash_start     = 1'b0;
    req            = '0;
    req.wr_key     = key_r;
    req.wr_val     = val_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_key == '0) begin
            res_status_nxt = ST_ZERO_KEY;
            res_value_nxt  = '0;
            res_slot_nxt   = '0;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        hash_start = !hash_done;
        if (hash_done) begin
          home_nxt  = hash_home;
          state_nxt = S_HOME_RD;
        end
      end
      S_HOME_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = home_r;
        state_nxt   = S_HOME_CHK;
      end
      S_HOME_CHK: begin
        home_empty_nxt = (key_rd == '0);
        ra_nxt         = '0;
        free_nxt       = 1'b0;
        res_value_nxt  = '0;
        res_slot_nxt   = '0;
        if (key_rd == key_r) begin
          res_slot_nxt = home_r;
          state_nxt    = S_DONE;
          if (op_r == OP_GET) begin
            res_status_nxt = ST_FOUND;
            res_value_nxt  = val_rd;
          end else begin
            res_status_nxt = ST_UPDATED;
            req.val_wr     = 1'b1;
            req.wr_addr    = home_r;
          end
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ra_r < lim) begin
          req.rd_en    = 1'b1;
          req.rd_addr  = ra_r[SLOT_W-1:0];
          ra_nxt       = ra_r + SIZE_W'(1);
          chk_nxt      = 1'b1;
          chk_slot_nxt = ra_r[SLOT_W-1:0];
        end
        if (chk_r && key_rd == key_r) begin
          res_slot_nxt = chk_slot_r;
          state_nxt    = S_DONE;
          if (op_r == OP_GET) begin
            res_status_nxt = ST_FOUND;
            res_value_nxt  = val_rd;
          end else begin
            res_status_nxt = ST_UPDATED;
            req.val_wr     = 1'b1;
            req.wr_addr    = chk_slot_r;
          end
        end else begin
          if (chk_r && key_rd == '0 && !free_r) begin
            free_nxt      = 1'b1;
            free_slot_nxt = chk_slot_r;
          end
          if (!chk_r && ra_r >= lim) begin
            state_nxt = S_DONE;
            if (op_r == OP_GET) begin
              res_status_nxt = ST_NOT_FOUND;
            end else if (home_empty_r) begin
              res_status_nxt = ST_INSERTED;
              res_slot_nxt   = home_r;
              req.key_wr     = 1'b1;
              req.val_wr     = 1'b1;
              req.wr_addr    = home_r;
              occ_nxt        = 1'b1;
            end else if (free_r) begin
              res_status_nxt = ST_INSERTED;
              res_slot_nxt   = free_slot_r;
              req.key_wr     = 1'b1;
              req.val_wr     = 1'b1;
              req.wr_addr    = free_slot_r;
              occ_nxt        = 1'b1;
              if (free_slot_r > hos_r) begin
                hos_nxt = free_slot_r;
              end
            end else begin
              res_status_nxt = ST_FULL;
            end
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= SIZE_W'(SLOTS);
      hos_r       <= '0;
      occ_r       <= 1'b0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hos_r   <= hos_nxt;
      occ_r   <= occ_nxt;
      chk_r   <= chk_nxt;
      if (cfg_valid && cfg_ready && !occ_r) begin
        size_r <= size_wr;
      end
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r  <= 1'b1;
        out_status_r <= res_status_r;
        out_value_r  <= res_value_r;
        out_slot_r   <= res_slot_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r  <= in_operation;
      key_r <= in_key;
      val_r <= in_value;
    end
    home_r       <= home_nxt;
    home_empty_r <= home_empty_nxt;
    ra_r         <= ra_nxt;
    chk_slot_r   <= chk_slot_nxt;
    free_r       <= free_nxt;
    free_slot_r  <= free_slot_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_slot_r   <= res_slot_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_value_r;
  assign out_slot       = out_slot_r;

  a_hos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, hos_r} < size_r)
    else $error("overflow mark beyond table size");

  a_insert_marks_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    req.key_wr |=> occ_r)
    else $error("insert did not mark table occupied");

  a_write_only_on_put: assert property (@(posedge clk) disable iff (!rst_n)
    (req.key_wr || req.val_wr) |-> (op_r == OP_PUT))
    else $error("store written during a get");

endmodule
